### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is applied
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

  localparam int unsigned COUNT_SATURATE_DEF = 511;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] MARK_START = 8'h01;
  localparam logic [7:0] MARK_MID   = 8'hFD;

  localparam int unsigned MIN_FRAME   = 2 + 4 + 1 + 2;
  localparam int unsigned MIN_PAYLOAD = 2 + 2 + 8;

  // byte positions within a segment
  localparam int unsigned POS_HDR_A   = 0;
  localparam int unsigned POS_HDR_T   = 1;
  localparam int unsigned POS_LEN     = 6;
  localparam int unsigned POS_MARK0   = 7;
  localparam int unsigned POS_TORQUE  = 8;
  localparam int unsigned POS_MARK1   = 9;
  localparam int unsigned POS_ID      = 10;
  localparam int unsigned POS_POS_HI  = 11;
  localparam int unsigned POS_POS_LO  = 12;
  localparam int unsigned POS_VEL_HI  = 13;
  localparam int unsigned POS_VEL_LO  = 14;
  localparam int unsigned POS_STF_HI  = 15;
  localparam int unsigned POS_STF_LO  = 16;
  localparam int unsigned POS_DMP_HI  = 17;
  localparam int unsigned POS_DMP_LO  = 18;

  typedef enum logic [1:0] {
    ST_DECODED      = 2'd0,
    ST_NO_PAYLOAD   = 2'd1,
    ST_LEN_MISMATCH = 2'd2,
    ST_BAD_HEADER   = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  motor_id;
    logic [7:0]  torque_code;
    logic [15:0] position_code;
    logic [15:0] velocity_code;
    logic [15:0] stiffness_code;
    logic [15:0] damping_code;
  } verdict_t;

  typedef struct packed {
    logic     close;
    verdict_t verdict;
  } cfd_result_t;

endpackage

`default_nettype wire

### hw/rtl/cfd_core.sv
`default_nettype none

module cfd_core
  import cfd_pkg::*;
#(
  parameter int unsigned COUNT_SATURATE = COUNT_SATURATE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output cfd_result_t result
);

  localparam int unsigned CW = $clog2(COUNT_SATURATE + 1);
  localparam logic [CW-1:0] SAT = CW'(COUNT_SATURATE);

  logic [CW-1:0] seg_count_r, seg_count_nxt;
  logic          last_cr_r, last_cr_nxt;
  logic          header_good_r, header_good_nxt;
  logic [7:0]    decl_len_r, decl_len_nxt;
  logic          markers_good_r, markers_good_nxt;
  logic [7:0]    held_torque_r, held_torque_nxt;
  logic [7:0]    held_id_r, held_id_nxt;
  logic [15:0]   held_pos_r, held_pos_nxt;
  logic [15:0]   held_vel_r, held_vel_nxt;
  logic [15:0]   held_stf_r, held_stf_nxt;
  logic [15:0]   held_dmp_r, held_dmp_nxt;

  logic [CW-1:0] total;
  logic [CW-1:0] frame_len;
  logic          close;
  logic          decoded;

  // field capture by position, including the current byte
  always_comb begin
    header_good_nxt  = header_good_r;
    decl_len_nxt     = decl_len_r;
    markers_good_nxt = markers_good_r;
    held_torque_nxt  = held_torque_r;
    held_id_nxt      = held_id_r;
    held_pos_nxt     = held_pos_r;
    held_vel_nxt     = held_vel_r;
    held_stf_nxt     = held_stf_r;
    held_dmp_nxt     = held_dmp_r;
    unique case (seg_count_r)
      CW'(POS_HDR_A):  header_good_nxt = (rx_byte == CHAR_A);
      CW'(POS_HDR_T):  header_good_nxt = header_good_r && (rx_byte == CHAR_T);
      CW'(POS_LEN):    decl_len_nxt = rx_byte;
      CW'(POS_MARK0):  markers_good_nxt = (rx_byte == MARK_START);
      CW'(POS_TORQUE): held_torque_nxt = rx_byte;
      CW'(POS_MARK1):  markers_good_nxt = markers_good_r && (rx_byte == MARK_MID);
      CW'(POS_ID):     held_id_nxt = rx_byte;
      CW'(POS_POS_HI): held_pos_nxt = {rx_byte, held_pos_r[7:0]};
      CW'(POS_POS_LO): held_pos_nxt = {held_pos_r[15:8], rx_byte};
      CW'(POS_VEL_HI): held_vel_nxt = {rx_byte, held_vel_r[7:0]};
      CW'(POS_VEL_LO): held_vel_nxt = {held_vel_r[15:8], rx_byte};
      CW'(POS_STF_HI): held_stf_nxt = {rx_byte, held_stf_r[7:0]};
      CW'(POS_STF_LO): held_stf_nxt = {held_stf_r[15:8], rx_byte};
      CW'(POS_DMP_HI): held_dmp_nxt = {rx_byte, held_dmp_r[7:0]};
      CW'(POS_DMP_LO): held_dmp_nxt = {held_dmp_r[15:8], rx_byte};
      default: ;
    endcase
  end

  assign total     = (seg_count_r < SAT) ? seg_count_r + CW'(1) : SAT;
  assign frame_len = CW'(MIN_FRAME) + CW'(decl_len_nxt);
  assign close     = (rx_byte == CHAR_LF) && last_cr_r;

  always_comb begin
    seg_count_nxt = close ? '0 : total;
    last_cr_nxt   = close ? 1'b0 : (rx_byte == CHAR_CR);
  end

  // verdict for the segment closed by this byte
  always_comb begin
    decoded = 1'b0;
    result  = '0;
    result.close = close;
    priority if (total < CW'(MIN_FRAME) || !header_good_nxt) begin
      result.verdict.status = ST_BAD_HEADER;
    end else if (total != frame_len) begin
      result.verdict.status = ST_LEN_MISMATCH;
    end else if (decl_len_nxt >= 8'(MIN_PAYLOAD) && markers_good_nxt) begin
      result.verdict.status = ST_DECODED;
      decoded = 1'b1;
    end else begin
      result.verdict.status = ST_NO_PAYLOAD;
    end
    if (decoded) begin
      result.verdict.motor_id       = held_id_nxt;
      result.verdict.torque_code    = held_torque_nxt;
      result.verdict.position_code  = held_pos_nxt;
      result.verdict.velocity_code  = held_vel_nxt;
      result.verdict.stiffness_code = held_stf_nxt;
      result.verdict.damping_code   = held_dmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
      last_cr_r   <= 1'b0;
    end else if (step) begin
      seg_count_r <= seg_count_nxt;
      last_cr_r   <= last_cr_nxt;
    end
  end

  // every field is written at its position before any verdict reads it
  always_ff @(posedge clk) begin
    if (step) begin
      header_good_r  <= header_good_nxt;
      decl_len_r     <= decl_len_nxt;
      markers_good_r <= markers_good_nxt;
      held_torque_r  <= held_torque_nxt;
      held_id_r      <= held_id_nxt;
      held_pos_r     <= held_pos_nxt;
      held_vel_r     <= held_vel_nxt;
      held_stf_r     <= held_stf_nxt;
      held_dmp_r     <= held_dmp_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/crlf_frame_deframer_unit.sv
// a transferred byte is held in in_byte_r; its verdict is registered in verdict_r for the out_ channel
// throughput: one byte per cycle, sustained while out_ready keeps up
// a byte that closes no segment produces no transfer on the out_ channel
// reset (rst_n low, synchronous) empties both stages and the segment count
`default_nettype none

module crlf_frame_deframer_unit
  import cfd_pkg::*;
#(
  parameter int unsigned COUNT_SATURATE = COUNT_SATURATE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_motor_id,
  output logic [7:0]  out_torque_code,
  output logic [15:0] out_position_code,
  output logic [15:0] out_velocity_code,
  output logic [15:0] out_stiffness_code,
  output logic [15:0] out_damping_code
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  verdict_t    verdict_r;
  cfd_result_t result;
  logic        proceed;

  cfd_core #(
    .COUNT_SATURATE(COUNT_SATURATE)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (proceed),
    .rx_byte(in_byte_r),
    .result (result)
  );

  assign proceed  = in_valid_r && (!result.close || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && result.close) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && result.close) begin
      verdict_r <= result.verdict;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = verdict_r.status;
  assign out_motor_id       = verdict_r.motor_id;
  assign out_torque_code    = verdict_r.torque_code;
  assign out_position_code  = verdict_r.position_code;
  assign out_velocity_code  = verdict_r.velocity_code;
  assign out_stiffness_code = verdict_r.stiffness_code;
  assign out_damping_code   = verdict_r.damping_code;

endmodule

`default_nettype wire

### hw/rtl/cfd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module cfd_checker
  import cfd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_motor_id,
  input wire logic [7:0]  out_torque_code,
  input wire logic [15:0] out_position_code,
  input wire logic [15:0] out_velocity_code,
  input wire logic [15:0] out_stiffness_code,
  input wire logic [15:0] out_damping_code
);

  logic        fields_zero;
  logic        stalled;
  logic        rejected;
  logic [81:0] out_all;

  assign fields_zero = (out_motor_id == '0) && (out_torque_code == '0) &&
                       (out_position_code == '0) && (out_velocity_code == '0) &&
                       (out_stiffness_code == '0) && (out_damping_code == '0);

  assign stalled  = out_valid && !out_ready;
  assign rejected = out_valid && (out_status != ST_DECODED);
  assign out_all  = {out_status, out_motor_id, out_torque_code, out_position_code,
                     out_velocity_code, out_stiffness_code, out_damping_code};

  // stalled verdict holds
  `CFD_ASSERT(a_out_hold, clk, rst_n, stalled |=> out_valid && $stable(out_all), "stall broken")

  // codes only on a decoded verdict
  `CFD_ASSERT(a_zero_fields, clk, rst_n, rejected |-> fields_zero, "codes on a reject")

  // nothing waiting downstream means the input side is open
  `CFD_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")

  // reset empties the output stage
  `CFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "verdict pending after reset")

endmodule

bind crlf_frame_deframer_unit cfd_checker u_cfd_checker (.*);

`default_nettype wire
